@@ rtl/nre_pkg.sv @@
// ---------------------------------------------------------------------------
// nre_pkg
// Shared types and constants for the nuclear repulsion energy core.
// ---------------------------------------------------------------------------
package nre_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ChargeW = 7;
  localparam int unsigned EnergyW = 48;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SumW    = 66;
  localparam int unsigned RootW   = 33;
  localparam int unsigned NumW    = 46;   // Zi*Zj (14 bits) << 32
  localparam int unsigned QuotW   = 46;
  localparam int unsigned AtomW   = 3 * CoordW + ChargeW;

  localparam logic [EnergyW-1:0] EnergyMax = {EnergyW{1'b1}};

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } nre_state_t;

endpackage

@@ rtl/nre_ram.sv @@
// ---------------------------------------------------------------------------
// nre_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module nre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nuclear_repulsion_energy_core.sv @@
// ---------------------------------------------------------------------------
// nuclear_repulsion_energy_core
// Sums Zi*Zj/rij over all non-coincident atom pairs of one molecule.
// ---------------------------------------------------------------------------
// Each accepted atom is paired with every atom already stored. One pair
// runs memory read, difference, three squaring steps, a 33-step bit-serial
// square root, a 46-step bit-serial divide and the accumulate. A coincident
// pair stops after the first root step. After the transfer, busy is high
// for the pairs, a final read check and the store write, and a new atom is
// accepted only while busy is low. An atom that finds the store full skips
// the pairs and goes from the read check straight to the done state. The atom
// store is one RAM of MAX_ATOMS entries read once per pair. The result
// is driven for one cycle with out_valid, in the same cycle that busy falls
// for the atom marked last; the receiver cannot stall it. Atoms beyond
// MAX_ATOMS are dropped and flagged.
module nuclear_repulsion_energy_core #(
  parameter int unsigned MAX_ATOMS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [nre_pkg::CoordW-1:0]  in_pos_x,
  input  logic signed [nre_pkg::CoordW-1:0]  in_pos_y,
  input  logic signed [nre_pkg::CoordW-1:0]  in_pos_z,
  input  logic [nre_pkg::ChargeW-1:0]   in_charge_number,
  input  logic                          in_last_atom,
  output logic                          out_valid,
  output logic [nre_pkg::EnergyW-1:0]   out_repulsion_energy,
  output logic                          out_energy_saturated,
  output logic                          out_coincident_found,
  output logic                          out_store_overflow,
  output logic [nre_pkg::CountW-1:0]    out_atom_total
);
  import nre_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ATOMS);
  localparam int unsigned CntW  = $clog2(MAX_ATOMS + 1);

  nre_state_t state_r, state_nxt;

  // new atom latched at transfer
  logic signed [CoordW-1:0] ax_r, ay_r, az_r;
  logic [ChargeW-1:0]       ac_r;
  logic                     last_r;

  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     k_r;
  logic [EnergyW-1:0]  energy_r;
  logic                sat_r, coinc_r, ovf_r;

  // per-pair datapath
  logic [CoordW:0]     dx_r, dy_r, dz_r;   // magnitudes, 33 bits
  logic [2*ChargeW-1:0] zz_r;
  logic [SumW-1:0]     sum_r;
  logic [1:0]          sq_ph_r;            // which square is being added
  logic [RootW-1:0]    root_r;
  logic [RootW+1:0]    rem_r;
  logic [SumW-1:0]     sh_r;               // radicand shifted out 2 bits a step
  logic [5:0]          step_r;
  logic [NumW-1:0]     num_r;
  logic [RootW:0]      drem_r;
  logic [QuotW-1:0]    quo_r;

  // RAM
  logic                ram_we;
  logic [AtomW-1:0]    ram_rdata;
  logic signed [CoordW-1:0] sx, sy, sz;
  logic [ChargeW-1:0]  sc;

  nre_ram #(.Width(AtomW), .Depth(MAX_ATOMS)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AddrW-1:0]),
    .wdata({ax_r, ay_r, az_r, ac_r}),
    .raddr(k_r[AddrW-1:0]),
    .rdata(ram_rdata)
  );
  assign {sx, sy, sz, sc} = ram_rdata;

  logic accept;
  assign accept = start && !busy;

  logic room;
  assign room = (count_r != CntW'(MAX_ATOMS));

  logic room_wr;
  assign room_wr = (count_r != CntW'(MAX_ATOMS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: begin
        if (!room || k_r == count_r) state_nxt = ST_DONE;
        else state_nxt = ST_DIFF;
      end
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   if (sq_ph_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sum_r == '0) state_nxt = ST_READ;
        else if (step_r == 6'd32) state_nxt = ST_DIV;
      end
      ST_DIV:  if (step_r == 6'd45) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_READ;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state_r != ST_IDLE);
    ram_we = (state_r == ST_DONE) && room_wr;
  end

  // helpers
  logic signed [CoordW:0] ddx, ddy, ddz;
  always_comb begin
    ddx = {ax_r[CoordW-1], ax_r} - {sx[CoordW-1], sx};
    ddy = {ay_r[CoordW-1], ay_r} - {sy[CoordW-1], sy};
    ddz = {az_r[CoordW-1], az_r} - {sz[CoordW-1], sz};
  end

  logic [CoordW:0]     sq_op;
  logic [2*CoordW+1:0] sq_val;
  always_comb begin
    case (sq_ph_r)
      2'd0:    sq_op = dx_r;
      2'd1:    sq_op = dy_r;
      default: sq_op = dz_r;
    endcase
    sq_val = sq_op * sq_op;   // 33x33, one per cycle
  end

  logic [RootW+1:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem_r[RootW-1:0], sh_r[SumW-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  logic [RootW:0] dsh;
  always_comb dsh = {drem_r[RootW-1:0], num_r[NumW-1]};

  logic [EnergyW:0] acc_sum;
  always_comb acc_sum = {1'b0, energy_r} + {{(EnergyW+1-QuotW){1'b0}}, quo_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      energy_r  <= '0;
      sat_r     <= 1'b0;
      coinc_r   <= 1'b0;
      ovf_r     <= 1'b0;
      out_valid <= 1'b0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: k_r <= '0;
        ST_READ: ;
        ST_SQRT: if (sum_r == '0) begin
          coinc_r <= 1'b1;
          k_r     <= k_r + 1'b1;
        end
        ST_ACC: begin
          k_r <= k_r + 1'b1;
          if (acc_sum[EnergyW]) begin
            energy_r <= EnergyMax;
            sat_r    <= 1'b1;
          end else begin
            energy_r <= acc_sum[EnergyW-1:0];
          end
        end
        ST_DONE: begin
          k_r <= '0;
          if (last_r) begin
            out_valid <= 1'b1;
            count_r   <= '0;
            energy_r  <= '0;
            sat_r     <= 1'b0;
            coinc_r   <= 1'b0;
            ovf_r     <= 1'b0;
          end else if (room_wr) begin
            count_r <= count_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (accept) begin
        ax_r <= in_pos_x; ay_r <= in_pos_y; az_r <= in_pos_z;
        ac_r <= in_charge_number; last_r <= in_last_atom;
      end
      ST_DIFF: begin
        dx_r    <= ddx[CoordW] ? (CoordW+1)'(0) - ddx : ddx;
        dy_r    <= ddy[CoordW] ? (CoordW+1)'(0) - ddy : ddy;
        dz_r    <= ddz[CoordW] ? (CoordW+1)'(0) - ddz : ddz;
        zz_r    <= ac_r * sc;
        sum_r   <= '0;
        sq_ph_r <= 2'd0;
      end
      ST_SQ: begin
        sum_r   <= sum_r + SumW'(sq_val);
        sq_ph_r <= sq_ph_r + 2'd1;
        sh_r    <= sum_r + SumW'(sq_val);
        root_r  <= '0;
        rem_r   <= '0;
        step_r  <= '0;
      end
      ST_SQRT: begin
        sh_r   <= {sh_r[SumW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
        if (step_r == 6'd32) begin
          num_r  <= {zz_r, 32'd0};
          drem_r <= '0;
          quo_r  <= '0;
          step_r <= '0;
        end else begin
          step_r <= step_r + 6'd1;
        end
      end
      ST_DIV: begin
        num_r  <= {num_r[NumW-2:0], 1'b0};
        step_r <= step_r + 6'd1;
        if (dsh >= {1'b0, root_r}) begin
          drem_r <= dsh - {1'b0, root_r};
          quo_r  <= {quo_r[QuotW-2:0], 1'b1};
        end else begin
          drem_r <= dsh;
          quo_r  <= {quo_r[QuotW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // result ports, valid with out_valid
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_repulsion_energy <= energy_r;
      out_energy_saturated <= sat_r;
      out_coincident_found <= coinc_r;
      out_store_overflow   <= ovf_r || !room_wr;
      out_atom_total       <= CountW'(room_wr ? count_r + 1'b1 : count_r);
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MAX_ATOMS)) else $error("atom count past capacity");
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= count_r) else $error("pair index past stored atoms");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");

endmodule

@@ tb/nuclear_repulsion_energy_core_test.sv @@
// ---------------------------------------------------------------------------
// nuclear_repulsion_energy_core_test
// Self-checking bench for the pairwise nuclear repulsion energy core.
// ---------------------------------------------------------------------------
// Atoms are sent one at a time with random gaps. A bit-exact energy predictor
// keeps its own atom store and accumulator and queues the expected molecule
// result on every atom marked last. Each out_valid transfer is checked field
// by field against the oldest queued molecule.
module nuclear_repulsion_energy_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nre_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned IdleLimit  = 50000;

  typedef struct {
    logic [EnergyW-1:0] energy;
    logic               sat;
    logic               coinc;
    logic               ovf;
    logic [CountW-1:0]  total;
  } molecule_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] in_pos_x = '0;
  logic signed [CoordW-1:0] in_pos_y = '0;
  logic signed [CoordW-1:0] in_pos_z = '0;
  logic [ChargeW-1:0] in_charge_number = '0;
  logic in_last_atom = 1'b0;
  logic out_valid;
  logic [EnergyW-1:0] out_repulsion_energy;
  logic out_energy_saturated;
  logic out_coincident_found;
  logic out_store_overflow;
  logic [CountW-1:0] out_atom_total;

  nuclear_repulsion_energy_core #(.MAX_ATOMS(StoreDepth)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_charge_number(in_charge_number), .in_last_atom(in_last_atom),
    .out_valid(out_valid), .out_repulsion_energy(out_repulsion_energy),
    .out_energy_saturated(out_energy_saturated),
    .out_coincident_found(out_coincident_found),
    .out_store_overflow(out_store_overflow), .out_atom_total(out_atom_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic signed [CoordW-1:0] atom_x [StoreDepth];
  logic signed [CoordW-1:0] atom_y [StoreDepth];
  logic signed [CoordW-1:0] atom_z [StoreDepth];
  logic [ChargeW-1:0]       atom_q [StoreDepth];
  int unsigned              atom_count = 0;
  logic [EnergyW:0]         energy_acc = '0;
  logic                     sat_seen = 1'b0;
  logic                     coinc_seen = 1'b0;
  logic                     ovf_seen = 1'b0;

  molecule_result_t pending_molecules[$];
  int unsigned errors = 0;
  int unsigned atoms_sent = 0;
  int unsigned molecules_checked = 0;
  int unsigned sat_results = 0;
  int unsigned coinc_results = 0;
  int unsigned ovf_results = 0;

  // floor(sqrt(v)) for a 66-bit value, two bits per step
  function automatic logic [RootW-1:0] int_sqrt(input logic [SumW-1:0] v);
    logic [SumW+1:0] rem;
    logic [SumW+1:0] trial;
    logic [RootW:0]  root;
    rem = '0;
    root = '0;
    for (int i = RootW - 1; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 2'b11);
      trial = ((SumW + 2)'(root) << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[RootW-1:0];
  endfunction

  function automatic logic [CoordW:0] abs_delta(input logic signed [CoordW-1:0] a,
                                                 input logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d < 0 ? -d : d;
  endfunction

  // Pair the new atom with the stored ones, store it, and queue a result on last
  task automatic predict_energy(input logic signed [CoordW-1:0] x,
                                input logic signed [CoordW-1:0] y,
                                input logic signed [CoordW-1:0] z,
                                input logic [ChargeW-1:0] q, input logic last);
    logic [CoordW:0]    a;
    logic [SumW-1:0]    dist_sq;
    logic [RootW-1:0]   r;
    logic [79:0]        num;
    logic [79:0]        term;
    molecule_result_t   res;
    if (atom_count < StoreDepth) begin
      for (int k = 0; k < atom_count; k++) begin
        a = abs_delta(x, atom_x[k]);
        dist_sq = SumW'(a) * SumW'(a);
        a = abs_delta(y, atom_y[k]);
        dist_sq = dist_sq + SumW'(a) * SumW'(a);
        a = abs_delta(z, atom_z[k]);
        dist_sq = dist_sq + SumW'(a) * SumW'(a);
        if (dist_sq == '0) begin
          coinc_seen = 1'b1;
        end else begin
          r = int_sqrt(dist_sq);
          num = (80'(q) * 80'(atom_q[k])) << 32;
          term = num / 80'(r);
          energy_acc = energy_acc + (EnergyW + 1)'(term);
          if (energy_acc > {1'b0, EnergyMax}) begin
            energy_acc = {1'b0, EnergyMax};
            sat_seen = 1'b1;
          end
        end
      end
      atom_x[atom_count] = x;
      atom_y[atom_count] = y;
      atom_z[atom_count] = z;
      atom_q[atom_count] = q;
      atom_count++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      res.energy = energy_acc[EnergyW-1:0];
      res.sat = sat_seen;
      res.coinc = coinc_seen;
      res.ovf = ovf_seen;
      res.total = CountW'(atom_count);
      pending_molecules = {pending_molecules, res};
      atom_count = 0;
      energy_acc = '0;
      sat_seen = 1'b0;
      coinc_seen = 1'b0;
      ovf_seen = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One atom transfer: optional idle gap, then hold start until accepted
  task automatic send_atom(input logic signed [CoordW-1:0] x,
                           input logic signed [CoordW-1:0] y,
                           input logic signed [CoordW-1:0] z,
                           input logic [ChargeW-1:0] q, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_charge_number <= q;
    in_last_atom <= last;
    do @(posedge clk); while (busy);
    predict_energy(x, y, z, q, last);
    atoms_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_molecules.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Result check
  always @(posedge clk) begin
    molecule_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_molecules.size() == 0) begin
        $display("%0t: unexpected result, energy %h", $time, out_repulsion_energy);
        errors++;
      end else begin
        exp_res = pending_molecules.pop_front();
        molecules_checked++;
        if (exp_res.sat) sat_results++;
        if (exp_res.coinc) coinc_results++;
        if (exp_res.ovf) ovf_results++;
        if (out_repulsion_energy !== exp_res.energy) begin
          $display("%0t: energy expected %h actual %h", $time, exp_res.energy,
                   out_repulsion_energy);
          errors++;
        end
        if (out_energy_saturated !== exp_res.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_res.sat,
                   out_energy_saturated);
          errors++;
        end
        if (out_coincident_found !== exp_res.coinc) begin
          $display("%0t: coincident expected %b actual %b", $time, exp_res.coinc,
                   out_coincident_found);
          errors++;
        end
        if (out_store_overflow !== exp_res.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_res.ovf,
                   out_store_overflow);
          errors++;
        end
        if (out_atom_total !== exp_res.total) begin
          $display("%0t: atom total expected %0d actual %0d", $time, exp_res.total,
                   out_atom_total);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, IdleLimit);
        $display("nuclear_repulsion_energy_core: mismatch");
        $finish;
      end
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord(input bit cluster);
    if (cluster) return $signed(CoordW'($urandom_range(0, 8))) - 4;
    return $urandom;
  endfunction

  // Corners of the coordinate range, max and zero charges
  task automatic test_extremes();
    send_atom(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 7'd127, 1'b0);
    send_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd127, 1'b0);
    send_atom(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 7'd0, 1'b0);
    send_atom(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 7'd1, 1'b1);
    // single-atom molecule
    send_atom(32'sh1234_5678, 32'shFFFF_FFFF, 32'sh0000_0001, 7'd127, 1'b1);
    // unit distance pair, and zero-charge pair
    send_atom(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 7'd1, 1'b0);
    send_atom(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 7'd1, 1'b1);
    send_atom(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 7'd0, 1'b0);
    send_atom(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000, 7'd99, 1'b1);
  endtask

  task automatic test_coincident();
    send_atom(32'sh0002_0000, 32'shFFFE_0000, 32'sh0000_8000, 7'd8, 1'b0);
    send_atom(32'sh0002_0000, 32'shFFFE_0000, 32'sh0000_8000, 7'd8, 1'b0);
    send_atom(32'sh0003_0000, 32'shFFFE_0000, 32'sh0000_8000, 7'd1, 1'b1);
  endtask

  // Tightly packed heavy atoms drive the sum past full scale
  task automatic test_saturation();
    for (int i = 0; i < 6; i++)
      send_atom(CoordW'(i), 32'sh0, 32'sh0, 7'd127, i == 5);
  endtask

  // Fill the store, then an extra atom that also carries last
  task automatic test_overflow();
    for (int i = 0; i <= StoreDepth; i++)
      send_atom(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                7'($urandom_range(0, 127)), i == StoreDepth);
  endtask

  // Random molecules, mostly small, some with clusters and repeated atoms
  task automatic test_random_molecules(input int unsigned atom_budget);
    int unsigned n;
    int unsigned roll;
    bit cluster;
    logic signed [CoordW-1:0] x, y, z;
    while (atoms_sent < atom_budget) begin
      roll = $urandom_range(0, 99);
      n = (roll < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      cluster = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        if (i == 0 || $urandom_range(0, 9) != 0) begin
          x = rand_coord(cluster);
          y = rand_coord(cluster);
          z = rand_coord(cluster);
        end
        send_atom(x, y, z, 7'($urandom_range(0, 127)), i == n - 1);
      end
      if ($urandom_range(0, 49) == 0) wait_all_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_coincident();
    wait_all_results();
    test_saturation();
    test_overflow();
    test_random_molecules(1300);
    wait_all_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d atoms, checked %0d molecules", atoms_sent, molecules_checked);
    $display("Results with saturation %0d, coincident pairs %0d, overflow %0d",
             sat_results, coinc_results, ovf_results);
    if (errors == 0) begin
      $display("nuclear_repulsion_energy_core: match");
    end else begin
      $display("nuclear_repulsion_energy_core: mismatch");
    end
    $finish;
  end

endmodule

@@ nuclear_repulsion_energy_core.f @@
rtl/nre_pkg.sv
rtl/nre_ram.sv
rtl/nuclear_repulsion_energy_core.sv
tb/nuclear_repulsion_energy_core_test.sv
